@@ hdl/imac_pkg.sv @@
package imac_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	localparam int VAL_W      = 8;
	localparam int LBL_W      = 8;
	localparam int MODE_W     = 2;
	localparam int ACC_W      = 64;
	localparam int NUM_SUMS   = 7;
	localparam int OUT_W      = NUM_SUMS * ACC_W;
	localparam int IN_W       = VAL_W + LBL_W;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam int WX_W  = VAL_W + XW;
	localparam int WY_W  = VAL_W + YW;
	localparam int WXX_W = WX_W + XW;
	localparam int WXY_W = WX_W + YW;
	localparam int WYY_W = WY_W + YW;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam logic [XW-1:0] COL_LAST = XW'(MAX_WIDTH - 1);
	localparam logic [YW-1:0] ROW_LAST = YW'(MAX_HEIGHT - 1);

	// weight modes; the unused code behaves as MODE_GATED
	localparam logic [MODE_W-1:0] MODE_VALUE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LABEL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GATED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_LABEL = 8'd1;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] w;
		logic [XW-1:0]    x;
		logic [YW-1:0]    y;
		logic             frame_end;
	} item_t;

	// pixel_count lands in the lowest bits
	typedef struct packed {
		logic [ACC_W-1:0] sum_wyy;
		logic [ACC_W-1:0] sum_wxy;
		logic [ACC_W-1:0] sum_wxx;
		logic [ACC_W-1:0] sum_wy;
		logic [ACC_W-1:0] sum_wx;
		logic [ACC_W-1:0] weight_sum;
		logic [ACC_W-1:0] pixel_count;
	} moments_t;

endpackage

@@ hdl/imac_front.sv @@
module imac_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [imac_pkg::VAL_W-1:0]       pixel_value,
	input  logic [imac_pkg::LBL_W-1:0]       pixel_label,
	input  logic                             row_end,
	input  logic                             frame_end,
	output logic                             in_ready,
	input  logic                             cfg_valid,
	input  logic [imac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [imac_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                             cfg_ready,
	input  logic                             fifo_full,
	output logic                             push,
	output imac_pkg::item_t                  push_item
);
	import imac_pkg::*;

	logic [MODE_W-1:0] weight_mode_q;
	logic [LBL_W-1:0]  match_label_q;
	logic [XW-1:0]     col_q;
	logic [YW-1:0]     row_q;
	logic              match;

	assign cfg_ready = 1'b1;
	assign in_ready  = !fifo_full;
	assign push      = in_valid && in_ready;
	assign match     = (pixel_label == match_label_q);

	always_comb begin
		push_item.x         = col_q;
		push_item.y         = row_q;
		push_item.frame_end = frame_end;
		case (weight_mode_q)
			MODE_VALUE: begin
				push_item.hit = 1'b1;
				push_item.w   = pixel_value;
			end
			MODE_LABEL: begin
				push_item.hit = match;
				push_item.w   = VAL_W'(match);
			end
			default: begin
				push_item.hit = match;
				push_item.w   = match ? pixel_value : '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_mode_q <= MODE_VALUE;
			match_label_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WEIGHT_MODE: weight_mode_q <= cfg_data[MODE_W-1:0];
				REG_MATCH_LABEL: match_label_q <= cfg_data[LBL_W-1:0];
				default: ;
			endcase
		end
	end

	// raster position, saturating at the last column and row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				if (row_q < ROW_LAST)
					row_q <= row_q + 1'b1;
			end else if (col_q < COL_LAST) begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

@@ hdl/imac_fifo.sv @@
module imac_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  imac_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output imac_pkg::item_t pop_item,
	output logic            empty
);
	import imac_pkg::*;

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full     = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("fifo count above depth");

	ap_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full fifo");

	ap_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty fifo");

endmodule

@@ hdl/imac_back.sv @@
module imac_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fifo_empty,
	input  imac_pkg::item_t              fifo_item,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [imac_pkg::OUT_W-1:0]   out_data
);
	import imac_pkg::*;

	logic              valid_s1;
	logic              hit_s1;
	logic [VAL_W-1:0]  w_s1;
	logic [XW-1:0]     x_s1;
	logic [YW-1:0]     y_s1;
	logic [WX_W-1:0]   wx_s1;
	logic [WY_W-1:0]   wy_s1;
	logic              fe_s1;

	logic              valid_s2;
	logic              hit_s2;
	logic [VAL_W-1:0]  w_s2;
	logic [WX_W-1:0]   wx_s2;
	logic [WY_W-1:0]   wy_s2;
	logic [WXX_W-1:0]  wxx_s2;
	logic [WXY_W-1:0]  wxy_s2;
	logic [WYY_W-1:0]  wyy_s2;
	logic              fe_s2;

	moments_t          acc_q;
	moments_t          acc_next;
	moments_t          out_q;
	logic              out_valid_q;
	logic              advance;

	// the whole pipe holds only when a frame result waits on a full output register
	assign advance   = !(valid_s2 && fe_s2 && out_valid_q && !out_ready);
	assign pop       = advance && !fifo_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		acc_next.pixel_count = acc_q.pixel_count + ACC_W'(hit_s2);
		acc_next.weight_sum  = acc_q.weight_sum + ACC_W'(w_s2);
		acc_next.sum_wx      = acc_q.sum_wx + ACC_W'(wx_s2);
		acc_next.sum_wy      = acc_q.sum_wy + ACC_W'(wy_s2);
		acc_next.sum_wxx     = acc_q.sum_wxx + ACC_W'(wxx_s2);
		acc_next.sum_wxy     = acc_q.sum_wxy + ACC_W'(wxy_s2);
		acc_next.sum_wyy     = acc_q.sum_wyy + ACC_W'(wyy_s2);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s1 <= fifo_item.hit;
			w_s1   <= fifo_item.w;
			x_s1   <= fifo_item.x;
			y_s1   <= fifo_item.y;
			fe_s1  <= fifo_item.frame_end;
			wx_s1  <= fifo_item.w * fifo_item.x;
			wy_s1  <= fifo_item.w * fifo_item.y;

			hit_s2 <= hit_s1;
			w_s2   <= w_s1;
			wx_s2  <= wx_s1;
			wy_s2  <= wy_s1;
			fe_s2  <= fe_s1;
			wxx_s2 <= wx_s1 * x_s1;
			wxy_s2 <= wx_s1 * y_s1;
			wyy_s2 <= wy_s1 * y_s1;
		end
		if (advance && valid_s2 && fe_s2)
			out_q <= acc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= pop;
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s2) begin
				if (fe_s2)
					acc_q <= '0;
				else
					acc_q <= acc_next;
			end
			if (advance && valid_s2 && fe_s2)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	ap_stall_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |-> (out_valid_q && valid_s2 && fe_s2))
		else $error("pipeline stalled without a pending result");

	ap_result_clears_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s2 && fe_s2) |=> (acc_q == '0) && out_valid_q)
		else $error("frame end did not clear sums or raise result");

	ap_stall_keeps_sums: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(acc_q))
		else $error("sums changed during a stall");

endmodule

@@ hdl/image_moments_accumulator_top.sv @@
// A frame's last pixel passes the queue, s1 and s2 before the result is registered.
// Throughput: one pixel per cycle unless stalled, set by the two-stage multiply pipe
// and 64-bit accumulators; a 4-entry queue decouples input from the multiply pipe.
// Input stalls only while a frame result waits on m_axis_tready and the queue fills.
// Reset (arst_n low, asynchronous): sums, position, queue and config cleared;
// weight_mode returns to value-only, match_label to 0.
module image_moments_accumulator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [7:0] pixel_value, [15:8] pixel_label
	input  logic [imac_pkg::IN_W-1:0]        s_axis_tdata,
	input  logic                             s_axis_tlast,  // row_end
	// [0] frame_end
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// from bit 0 up, 64 bits each: pixel_count, weight_sum, sum_wx, sum_wy,
	// sum_wxx, sum_wxy, sum_wyy
	output logic [imac_pkg::OUT_W-1:0]       m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [imac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [imac_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import imac_pkg::*;

	logic  push;
	item_t push_item;
	logic  fifo_full;
	logic  pop;
	item_t pop_item;
	logic  fifo_empty;

	imac_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.pixel_value (s_axis_tdata[VAL_W-1:0]),
		.pixel_label (s_axis_tdata[IN_W-1:VAL_W]),
		.row_end     (s_axis_tlast),
		.frame_end   (s_axis_tuser),
		.in_ready    (s_axis_tready),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cfg_ready   (cfg_ready),
		.fifo_full   (fifo_full),
		.push        (push),
		.push_item   (push_item)
	);

	imac_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (fifo_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (fifo_empty)
	);

	imac_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.fifo_item  (pop_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata)
	);

endmodule
